// ===== design/stac_pkg.sv =====
// Package for the segment table allocation checker.
// Types and sizing constants shared by the cell row and the top level.
// No dependencies.
`default_nettype none

package stac_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int SEG_W  = 12;
    localparam int BASE_W = 10;
    localparam int LEN_W  = 10;
    localparam int END_W  = 11;
    localparam int MSZ_W  = 16;

    localparam logic [MSZ_W-1:0] MEMORY_SIZE_RESET = 16'd1024;

    // request type codes
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_ACCESS = 1'b1;

    // request token that walks the cell row
    typedef struct packed {
        logic              vld;
        logic              req_type;
        logic [SEG_W-1:0]  seg;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [END_W-1:0]  req_end;
        logic              bound_flt;
        logic              hit;
    } tok_t;

    // table write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [SEG_W-1:0]  seg;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } wr_t;

endpackage

`default_nettype wire

// ===== design/stac_cell.sv =====
// One cell of the region table row: holds one region and checks the passing token.
// Depends on stac_pkg.
`default_nettype none

module stac_cell (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire  [stac_pkg::IDX_W-1:0]      idx_i,
    input  wire  [stac_pkg::COUNT_W-1:0]    count_i,
    input  stac_pkg::wr_t                   wr_i,
    input  stac_pkg::tok_t                  tok_i,
    output stac_pkg::tok_t                  tok_o
);

    logic [stac_pkg::SEG_W-1:0]  seg_reg;
    logic [stac_pkg::BASE_W-1:0] base_reg;
    logic [stac_pkg::LEN_W-1:0]  len_reg;
    stac_pkg::tok_t              tok_reg;
    stac_pkg::tok_t              tok_next;

    logic                        entry_vld;
    logic [stac_pkg::END_W-1:0]  cb;
    logic [stac_pkg::END_W-1:0]  ce;
    logic [stac_pkg::END_W-1:0]  nb;
    logic                        overlap;
    logic                        contain;
    logic                        match;

    // entries below the fill count are live
    assign entry_vld = {{(stac_pkg::COUNT_W - stac_pkg::IDX_W){1'b0}}, idx_i} < count_i;

    // inclusive spans
    assign cb = {1'b0, base_reg};
    assign ce = {1'b0, base_reg} + {1'b0, len_reg};
    assign nb = {1'b0, tok_i.base};

    assign overlap = (cb <= nb && nb <= ce) || (cb <= tok_i.req_end && tok_i.req_end <= ce) ||
                     (nb <= cb && ce <= tok_i.req_end);
    assign contain = (cb <= nb) && (tok_i.req_end <= ce);

    always_comb begin
        match = 1'b0;
        if (entry_vld && (seg_reg == tok_i.seg)) begin
            unique case (tok_i.req_type)
                stac_pkg::REQ_ALLOC:  match = overlap;
                stac_pkg::REQ_ACCESS: match = contain;
                default:              match = 1'b0;
            endcase
        end
        tok_next     = tok_i;
        tok_next.hit = tok_i.hit | match;
    end

    // token stage to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // region storage, written by broadcast
    always_ff @(posedge aclk) begin
        if (wr_i.en && (wr_i.idx == idx_i)) begin
            seg_reg  <= wr_i.seg;
            base_reg <= wr_i.base;
            len_reg  <= wr_i.len;
        end
    end

    assign tok_o = tok_reg;

endmodule

`default_nettype wire

// ===== design/segment_table_alloc_check_core.sv =====
// Top level of the segment table allocation checker: cell row, fill count,
// result register and configuration register. Depends on stac_pkg, stac_cell.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | s_valid s_ready s_req_type s_segment_id  | in
//           | s_region_base s_region_length           |
//   result  | m_valid m_ready m_fault                 | out
//   config  | cfg_valid cfg_ready cfg_data            | in
//
// An item walks the row of TABLE_DEPTH cells, one cell a cycle; at the end
// of the row its result is written to the output register, and the next
// item is taken only once that has happened, so the block holds one item
// at a time. A stalled result holds in a pending register and the block
// takes no item until it reaches the output register.
// Reset clears the fill count and the result path; memory_size goes to 1024.
`default_nettype none

module segment_table_alloc_check_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_req_type,
    input  wire  [stac_pkg::SEG_W-1:0]         s_segment_id,
    input  wire  [stac_pkg::BASE_W-1:0]        s_region_base,
    input  wire  [stac_pkg::LEN_W-1:0]         s_region_length,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_fault,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [stac_pkg::MSZ_W-1:0]         cfg_data
);

    logic [stac_pkg::MSZ_W-1:0]   memory_size_reg;
    logic [stac_pkg::COUNT_W-1:0] count_reg;
    logic                         busy_reg;
    logic                         pend_vld_reg;
    logic                         pend_fault_reg;
    logic                         m_valid_reg;
    logic                         m_fault_reg;

    stac_pkg::tok_t               chain [stac_pkg::TABLE_DEPTH+1];
    stac_pkg::tok_t               head_tok;
    stac_pkg::wr_t                wr;
    stac_pkg::tok_t               done_tok;

    logic                         accept;
    logic                         out_free;
    logic                         full;
    logic                         fault_res;
    logic [stac_pkg::END_W-1:0]   req_end;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // token entering the row; the bound check is done up front
    assign req_end = {1'b0, s_region_base} + {1'b0, s_region_length};
    always_comb begin
        head_tok.vld       = accept;
        head_tok.req_type  = s_req_type;
        head_tok.seg       = s_segment_id;
        head_tok.base      = s_region_base;
        head_tok.len       = s_region_length;
        head_tok.req_end   = req_end;
        head_tok.bound_flt = {{(stac_pkg::MSZ_W - stac_pkg::END_W){1'b0}}, req_end} >
                             memory_size_reg;
        head_tok.hit       = 1'b0;
    end

    assign chain[0] = head_tok;

    // the cell row
    for (genvar i = 0; i < stac_pkg::TABLE_DEPTH; i++) begin : g_cell
        stac_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx_i   (stac_pkg::IDX_W'(i)),
            .count_i (count_reg),
            .wr_i    (wr),
            .tok_i   (chain[i]),
            .tok_o   (chain[i+1])
        );
    end

    // final verdict at the end of the row
    assign done_tok = chain[stac_pkg::TABLE_DEPTH];
    assign full     = (count_reg == stac_pkg::COUNT_W'(stac_pkg::TABLE_DEPTH));

    always_comb begin
        unique case (done_tok.req_type)
            stac_pkg::REQ_ALLOC:  fault_res = done_tok.bound_flt | done_tok.hit | full;
            stac_pkg::REQ_ACCESS: fault_res = done_tok.bound_flt | !done_tok.hit;
            default:              fault_res = 1'b1;
        endcase
    end

    // store a granted allocation at the fill count
    always_comb begin
        wr.en   = done_tok.vld && (done_tok.req_type == stac_pkg::REQ_ALLOC) && !fault_res;
        wr.idx  = count_reg[stac_pkg::IDX_W-1:0];
        wr.seg  = done_tok.seg;
        wr.base = done_tok.base;
        wr.len  = done_tok.len;
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (wr.en) begin
            count_reg <= count_reg + stac_pkg::COUNT_W'(1);
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_size_reg <= stac_pkg::MEMORY_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            memory_size_reg <= cfg_data;
        end
    end

    // result path: output register with a pending slot behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end
            if (done_tok.vld) begin
                if (out_free) begin
                    m_valid_reg <= 1'b1;
                    m_fault_reg <= fault_res;
                    busy_reg    <= 1'b0;
                end else begin
                    pend_vld_reg   <= 1'b1;
                    pend_fault_reg <= fault_res;
                end
            end else if (pend_vld_reg && out_free) begin
                m_valid_reg  <= 1'b1;
                m_fault_reg  <= pend_fault_reg;
                pend_vld_reg <= 1'b0;
                busy_reg     <= 1'b0;
            end else if (m_ready) begin
                // result taken, nothing new behind it
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_fault = m_fault_reg;

endmodule

`default_nettype wire

// ===== design/stac_checker.sv =====
// Port-level checks for the segment table allocation checker, and their bind.
// Depends on segment_table_alloc_check_core.
`default_nettype none

module stac_checker (
    input wire aclk,
    input wire aresetn,
    input wire s_valid,
    input wire s_ready,
    input wire m_valid,
    input wire m_ready,
    input wire m_fault,
    input wire cfg_ready
);

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item at a time: ready drops right after an item is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_fault)))
        else $error("stalled result changed");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind segment_table_alloc_check_core stac_checker u_stac_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_fault   (m_fault),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
